// ===== rtl/core/rlp_pkg.sv =====
`default_nettype none

package rlp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int VALUE_OUT_W = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int KILO_SHIFT  = 10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UD    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_UH    = 8'h48;
    localparam logic [CHAR_W-1:0] CH_UK    = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_UO    = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_UQ    = 8'h51;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;
    localparam logic [CHAR_W-1:0] DIGIT_LETTER_OFS = 8'h0A;
    localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

    typedef enum logic [1:0] {
        PH_BLANKS,
        PH_FIRST,
        PH_AFTER_ZERO,
        PH_BODY
    } phase_t;

    // Encoding matches the bit order of the digit fit flags.
    typedef enum logic [1:0] {
        BASE_BIN = 2'd0,
        BASE_OCT = 2'd1,
        BASE_DEC = 2'd2,
        BASE_HEX = 2'd3
    } base_t;

    typedef struct packed {
        logic                   ok;
        logic                   neg;
        logic                   kilo;
        logic [VALUE_WIDTH-1:0] acc;
    } fin_t;

    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        if (c >= CH_LA && c <= CH_LZ)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = upcase(c);
        if (u >= CH_ZERO && u <= CH_NINE)
        begin
            return u - CH_ZERO;
        end
        if (u >= CH_UA && u <= CH_UZ)
        begin
            return u - CH_UA + DIGIT_LETTER_OFS;
        end
        return NO_DIGIT;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rlp_char_if.sv =====
`default_nettype none

interface rlp_char_if
    import rlp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rlp_result_if.sv =====
`default_nettype none

interface rlp_result_if
    import rlp_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic signed [VALUE_OUT_W-1:0] value;

    modport source (output valid, output ok, output value, input ready);
    modport sink   (input valid, input ok, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rlp_scan.sv =====
`default_nettype none

module rlp_scan
    import rlp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rlp_char_if.sink    chars,
    input  wire logic   fin_ready,
    output logic        fin_valid,
    output fin_t        fin
);

    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic                   zero_prefix_reg, zero_prefix_next;
    logic                   hex_prefix_reg, hex_prefix_next;
    logic [CHAR_W-1:0]      held_char_reg, held_char_next;
    logic                   have_held_reg, have_held_next;
    logic [VALUE_WIDTH-1:0] acc_bin_reg, acc_bin_next;
    logic [VALUE_WIDTH-1:0] acc_oct_reg, acc_oct_next;
    logic [VALUE_WIDTH-1:0] acc_dec_reg, acc_dec_next;
    logic [VALUE_WIDTH-1:0] acc_hex_reg, acc_hex_next;
    logic [3:0]             fit_reg, fit_next;
    logic                   fin_valid_reg, fin_valid_next;
    fin_t                   fin_reg, fin_next;

    logic [CHAR_W-1:0]      c;
    logic [CHAR_W-1:0]      held_digit;
    logic [VALUE_WIDTH-1:0] d_ext;
    logic [VALUE_WIDTH-1:0] push_bin, push_oct, push_dec, push_hex;
    logic [3:0]             push_fit;
    logic                   accept;
    logic                   is_blank, is_sign;
    phase_t                 eff_phase;
    logic                   do_body;
    logic [CHAR_W-1:0]      body_c;
    logic                   use_push;
    base_t                  base;
    logic                   kilo;
    logic [VALUE_WIDTH-1:0] sel_acc;
    logic [3:0]             sel_fit;

    assign c          = chars.char_code;
    assign accept     = chars.valid && chars.ready;
    assign chars.ready = !fin_valid_reg || fin_ready;
    assign fin_valid  = fin_valid_reg;
    assign fin        = fin_reg;

    assign held_digit = digit_of(held_char_reg);
    assign d_ext      = VALUE_WIDTH'(held_digit[DIGIT_W-1:0]);
    assign push_bin   = (acc_bin_reg << 1) + d_ext;
    assign push_oct   = (acc_oct_reg << 3) + d_ext;
    assign push_dec   = (acc_dec_reg << 3) + (acc_dec_reg << 1) + d_ext;
    assign push_hex   = (acc_hex_reg << 4) + d_ext;

    always_comb
    begin
        push_fit = fit_reg;
        if (held_digit >= 8'd2)
        begin
            push_fit[BASE_BIN] = 1'b0;
        end
        if (held_digit >= 8'd8)
        begin
            push_fit[BASE_OCT] = 1'b0;
        end
        if (held_digit >= 8'd10)
        begin
            push_fit[BASE_DEC] = 1'b0;
        end
        if (held_digit >= 8'd16)
        begin
            push_fit[BASE_HEX] = 1'b0;
        end
    end

    assign is_blank  = (c == CH_SPACE) || (c == CH_TAB);
    assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
    assign eff_phase = (phase_reg == PH_BLANKS) ? PH_FIRST : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BLANKS;
            neg_reg         <= 1'b0;
            zero_prefix_reg <= 1'b0;
            hex_prefix_reg  <= 1'b0;
            held_char_reg   <= '0;
            have_held_reg   <= 1'b0;
            acc_bin_reg     <= '0;
            acc_oct_reg     <= '0;
            acc_dec_reg     <= '0;
            acc_hex_reg     <= '0;
            fit_reg         <= '1;
            fin_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            neg_reg         <= neg_next;
            zero_prefix_reg <= zero_prefix_next;
            hex_prefix_reg  <= hex_prefix_next;
            held_char_reg   <= held_char_next;
            have_held_reg   <= have_held_next;
            acc_bin_reg     <= acc_bin_next;
            acc_oct_reg     <= acc_oct_next;
            acc_dec_reg     <= acc_dec_next;
            acc_hex_reg     <= acc_hex_next;
            fit_reg         <= fit_next;
            fin_valid_reg   <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        neg_next         = neg_reg;
        zero_prefix_next = zero_prefix_reg;
        hex_prefix_next  = hex_prefix_reg;
        held_char_next   = held_char_reg;
        have_held_next   = have_held_reg;
        acc_bin_next     = acc_bin_reg;
        acc_oct_next     = acc_oct_reg;
        acc_dec_next     = acc_dec_reg;
        acc_hex_next     = acc_hex_reg;
        fit_next         = fit_reg;
        fin_valid_next   = fin_valid_reg;
        fin_next         = fin_reg;
        do_body          = 1'b0;
        body_c           = c;
        use_push         = 1'b0;
        base             = BASE_DEC;
        kilo             = 1'b0;

        // The held character is a suffix candidate until the string ends.
        if (zero_prefix_reg)
        begin
            use_push = have_held_reg;
            base     = hex_prefix_reg ? BASE_HEX : BASE_OCT;
        end
        else if (have_held_reg)
        begin
            unique case (upcase(held_char_reg))
                CH_UB:         base = BASE_BIN;
                CH_UO, CH_UQ:  base = BASE_OCT;
                CH_UD, CH_DOT: base = BASE_DEC;
                CH_UH:         base = BASE_HEX;
                CH_UK:         kilo = 1'b1;
                default:       use_push = 1'b1;
            endcase
        end

        sel_fit = use_push ? push_fit : fit_reg;
        unique case (base)
            BASE_BIN: sel_acc = use_push ? push_bin : acc_bin_reg;
            BASE_OCT: sel_acc = use_push ? push_oct : acc_oct_reg;
            BASE_DEC: sel_acc = use_push ? push_dec : acc_dec_reg;
            BASE_HEX: sel_acc = use_push ? push_hex : acc_hex_reg;
            default:  sel_acc = acc_dec_reg;
        endcase

        if (fin_ready)
        begin
            fin_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (c != CH_NUL)
            begin
                if (phase_reg == PH_BLANKS && is_blank)
                begin
                    phase_next = PH_BLANKS;
                end
                else if (phase_reg == PH_BLANKS && is_sign)
                begin
                    neg_next   = (c == CH_MINUS);
                    phase_next = PH_FIRST;
                end
                else
                begin
                    do_body = 1'b1;
                    unique case (eff_phase)
                        PH_FIRST:
                        begin
                            if (c == CH_ZERO)
                            begin
                                zero_prefix_next = 1'b1;
                                phase_next       = PH_AFTER_ZERO;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        PH_AFTER_ZERO:
                        begin
                            phase_next = PH_BODY;
                            if (upcase(c) == CH_UX)
                            begin
                                hex_prefix_next = 1'b1;
                                body_c          = CH_ZERO;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_BODY;
                        end
                    endcase
                end

                if (do_body)
                begin
                    if (have_held_reg)
                    begin
                        acc_bin_next = push_bin;
                        acc_oct_next = push_oct;
                        acc_dec_next = push_dec;
                        acc_hex_next = push_hex;
                        fit_next     = push_fit;
                    end
                    held_char_next = body_c;
                    have_held_next = 1'b1;
                end
            end
            else
            begin
                fin_valid_next   = 1'b1;
                fin_next.ok      = (phase_reg != PH_BLANKS) && sel_fit[base];
                fin_next.neg     = neg_reg;
                fin_next.kilo    = kilo;
                fin_next.acc     = sel_acc;
                phase_next       = PH_BLANKS;
                neg_next         = 1'b0;
                zero_prefix_next = 1'b0;
                hex_prefix_next  = 1'b0;
                held_char_next   = '0;
                have_held_next   = 1'b0;
                acc_bin_next     = '0;
                acc_oct_next     = '0;
                acc_dec_next     = '0;
                acc_hex_next     = '0;
                fit_next         = '1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rlp_result.sv =====
`default_nettype none

module rlp_result
    import rlp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fin_valid,
    input  wire fin_t     fin,
    output logic          fin_ready,
    rlp_result_if.source  results
);

    logic                          out_valid_reg, out_valid_next;
    logic                          ok_reg, ok_next;
    logic signed [VALUE_OUT_W-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0]        signed_acc;
    logic [VALUE_WIDTH-1:0]        scaled;

    assign fin_ready     = !out_valid_reg || results.ready;
    assign results.valid = out_valid_reg;
    assign results.ok    = ok_reg;
    assign results.value = value_reg;

    assign signed_acc = fin.neg ? (VALUE_WIDTH'(0) - fin.acc) : fin.acc;
    assign scaled     = fin.kilo ? (signed_acc << KILO_SHIFT) : signed_acc;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        value_next     = value_reg;
        if (fin_ready)
        begin
            out_valid_next = fin_valid;
            if (fin_valid)
            begin
                ok_next    = fin.ok;
                value_next = fin.ok ? VALUE_OUT_W'(signed'(scaled)) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/radix_literal_parser_unit.sv =====
// Parses an ASCII integer literal that arrives one character per transfer.
// The chars channel carries char_code; a NUL character ends the string.
// Leading blanks and one sign are skipped; the base comes from a 0 or 0x
// prefix or a B, O, Q, D, '.' or H suffix, else decimal; K scales by 1024.
// Each finished string yields one transfer on the results channel with ok
// and the signed value, which wraps to the value width; value is 0 when ok
// is 0.
// Throughput is one character per cycle while chars is not held off: the
// parser state and the four base accumulators update in the cycle a
// character is accepted. From the NUL transfer, the result passes through
// the parse register and then the output register before it is valid.
// When the receiver stalls, the finished result holds in the output
// register and the next result can wait in the parse register; chars is
// held off whenever the parse register holds a result that cannot move on.
// Reset clears the parse state, so the next character starts a new string,
// and drops any result not yet transferred.
`default_nettype none

module radix_literal_parser_unit
    import rlp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rlp_char_if.sink     chars,
    rlp_result_if.source results
);

    logic fin_valid;
    logic fin_ready;
    fin_t fin;

    rlp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .fin_ready (fin_ready),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    rlp_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready),
        .results   (results)
    );

endmodule

`default_nettype wire
